// ===== rtl/core/pkbd_pkg.sv =====
// Package for the per-key burst detector: sizes, codes and shared types.
`timescale 1ns / 1ps
package pkbd_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int KEY_BITS      = 22;
	localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
	localparam int FILL_BITS     = $clog2(TABLE_ENTRIES + 1);
	localparam int TIME_BITS     = 32;
	localparam int WINDOW_BITS   = 16;
	localparam int COUNT_BITS    = 8;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW    = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 1'b1;

	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET    = 16'd5;
	localparam logic [COUNT_BITS-1:0]  THRESHOLD_RESET = 8'd3;
	localparam logic [COUNT_BITS-1:0]  COUNT_MAX       = 8'hFF;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [TIME_BITS-1:0]  start;
		logic [COUNT_BITS-1:0] count;
		logic                  mark;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_WRITE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // latch a new request
		logic rd;     // read entry at scan index
		logic check;  // evaluate read entry
		logic step;   // advance scan index
		logic wr;     // write back and post result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;
		logic last;
		logic empty;
	} status_t;

endpackage

// ===== rtl/core/pkbd_ctrl.sv =====
// Controller state machine for the per-key burst detector.
`timescale 1ns / 1ps
module pkbd_ctrl
	import pkbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = status.empty ? ST_WRITE : ST_READ;
				end
			end
			ST_READ: begin
				state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.hit || status.last) begin
					state_nxt = ST_WRITE;
				end else begin
					state_nxt = ST_READ;
				end
			end
			ST_WRITE: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				cmd.step  = !(status.hit || status.last);
			end
			ST_WRITE: begin
				cmd.wr = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/core/pkbd_datapath.sv =====
// Datapath: entry table, scan index, oldest-entry tracker, config registers and result.
`timescale 1ns / 1ps
module pkbd_datapath
	import pkbd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output status_t                  status,
	input  logic [KEY_BITS-1:0]      event_key,
	input  logic [TIME_BITS-1:0]     current_time,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic                     done,
	output logic                     alarm
);

	entry_t mem [TABLE_ENTRIES];

	logic [WINDOW_BITS-1:0] window_q;
	logic [COUNT_BITS-1:0]  threshold_q;
	logic [FILL_BITS-1:0]   fill_q;
	logic [IDX_BITS-1:0]    idx_q;
	logic [IDX_BITS-1:0]    oldest_idx_q;
	logic [TIME_BITS-1:0]   oldest_start_q;
	logic                   hit_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [TIME_BITS-1:0]   now_q;
	entry_t                 rd_q;
	logic                   done_q;
	logic                   alarm_q;

	logic                   full;
	logic                   key_match;
	logic [TIME_BITS-1:0]   age;
	logic                   in_window;
	logic [COUNT_BITS-1:0]  count_inc;
	logic                   raise;
	logic [IDX_BITS-1:0]    wr_slot;
	entry_t                 wr_entry;

	assign full      = (fill_q == FILL_BITS'(TABLE_ENTRIES));
	assign key_match = (rd_q.key == key_q);

	assign status.hit   = key_match;
	assign status.last  = ({1'b0, idx_q} == FILL_BITS'(fill_q - 1'b1));
	assign status.empty = (fill_q == '0);

	assign age       = now_q - rd_q.start;
	assign in_window = (age <= {{(TIME_BITS-WINDOW_BITS){1'b0}}, window_q});
	assign count_inc = (rd_q.count == COUNT_MAX) ? COUNT_MAX : rd_q.count + 1'b1;
	assign raise     = hit_q && in_window && (count_inc >= threshold_q) && !rd_q.mark;

	always_comb begin
		wr_entry.key   = key_q;
		wr_entry.start = now_q;
		wr_entry.count = COUNT_BITS'(1);
		wr_entry.mark  = 1'b0;
		if (hit_q) begin
			wr_slot = idx_q;
			if (in_window) begin
				wr_entry.start = rd_q.start;
				wr_entry.count = count_inc;
				wr_entry.mark  = rd_q.mark | raise;
			end
		end else if (full) begin
			wr_slot = oldest_idx_q;
		end else begin
			wr_slot = fill_q[IDX_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_slot] <= wr_entry;
		end
		if (cmd.rd) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= event_key;
			now_q <= current_time;
		end
		// strict less-than keeps the lowest index on ties
		if (cmd.check && ((idx_q == '0) || (rd_q.start < oldest_start_q))) begin
			oldest_idx_q   <= idx_q;
			oldest_start_q <= rd_q.start;
		end
		if (cmd.wr) begin
			alarm_q <= raise;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			threshold_q <= THRESHOLD_RESET;
			fill_q      <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW:    window_q    <= cfg_data;
					REG_THRESHOLD: threshold_q <= cfg_data[COUNT_BITS-1:0];
					default:       ;
				endcase
			end
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.check && key_match) begin
				hit_q <= 1'b1;
			end
			if (cmd.wr && !hit_q && !full) begin
				fill_q <= fill_q + 1'b1;
			end
			done_q <= cmd.wr;
		end
	end

	assign done  = done_q;
	assign alarm = alarm_q;

endmodule

// ===== rtl/core/per_key_burst_detector.sv =====
// Top level of the per-key burst detector: controller plus datapath.
//
//  channel   signals                          direction  accepted when
//  request   start, event_key, current_time   in         start && !busy
//  result    done, alarm                      out        done (one cycle)
//  config    cfg_we, cfg_index, cfg_data      in         cfg_we
//
// A request scans the table one entry at a time (read, then check) from index 0,
// stopping at the first key match or after the last entry in use, then writes the
// entry back: no entries are scanned on an empty table, up to 64 otherwise. The result
// strobe follows the write cycle; a new request may be taken in that same cycle.
// The single table read port is why entries are scanned one at a time.
// Reset clears the fill count and loads the register defaults; results cannot stall.
`timescale 1ns / 1ps
module per_key_burst_detector
	import pkbd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [KEY_BITS-1:0]      event_key,
	input  logic [TIME_BITS-1:0]     current_time,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic                     done,
	output logic                     alarm
);

	cmd_t    cmd;
	status_t status;

	pkbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	pkbd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.event_key    (event_key),
		.current_time (current_time),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.alarm        (alarm)
	);

endmodule
